[sv/ple_pkg.sv]
package ple_pkg;

  // Beat field widths
  localparam int unsigned OpW    = 4;
  localparam int unsigned ValW   = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned StW    = 2;
  localparam int unsigned CntW   = 6;
  localparam int unsigned InDataW  = 48;  // 42 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 40;

  // Command opcodes
  localparam logic [OpW-1:0] OP_INS_FRONT = 4'd0;
  localparam logic [OpW-1:0] OP_INS_END   = 4'd1;
  localparam logic [OpW-1:0] OP_INS_POS   = 4'd2;
  localparam logic [OpW-1:0] OP_REM_FRONT = 4'd3;
  localparam logic [OpW-1:0] OP_REM_END   = 4'd4;
  localparam logic [OpW-1:0] OP_REM_POS   = 4'd5;
  localparam logic [OpW-1:0] OP_RD_FRONT  = 4'd6;
  localparam logic [OpW-1:0] OP_RD_END    = 4'd7;
  localparam logic [OpW-1:0] OP_RD_POS    = 4'd8;

  // Result status codes
  localparam logic [StW-1:0] ST_OK     = 2'd0;
  localparam logic [StW-1:0] ST_EMPTY  = 2'd1;
  localparam logic [StW-1:0] ST_BADPOS = 2'd2;
  localparam logic [StW-1:0] ST_FULL   = 2'd3;

endpackage

[sv/ple_ram.sv]
module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/positional_list_engine.sv]
// Channel   Dir  tdata fields (low bit up)                       Beat rule
// s_axis    in   opcode[3:0] value[35:4] position[41:36] pad     tvalid & tready
// m_axis    out  read_value[31:0] status[33:32] count[39:34]     tvalid & tready
//
// One command at a time. Entries live in a single-port-write RAM; shifts walk it
// one entry per cycle (read i, write its neighbor the next cycle).
// Insert at p shifts entries p and up by one, then writes the slot; remove at p
// reads entry p, then shifts the later entries down; reads skip the shift.
// s_axis_tready is low while a command runs; a finished result waits in the
// output register, and a stalled m_axis holds the sequencer in its last step.
// Reset empties the list at once; RAM contents need no clearing.
module positional_list_engine #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // opcode[3:0], value[35:4], position[41:36], zero pad[47:42]
  input  logic [ple_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_value[31:0], status[33:32], count[39:34]
  output logic [ple_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > ple_pkg::PosW) ? CW : ple_pkg::PosW;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_SHIFT = 3'd1;
  localparam logic [2:0] S_INS_PUT   = 3'd2;
  localparam logic [2:0] S_TAKE      = 3'd3;
  localparam logic [2:0] S_REM_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          m_valid_q, m_valid_d;

  // Per-command working registers
  logic [AW-1:0]                ptr_q, ptr_d;
  logic [AW-1:0]                pos_q, pos_d;
  logic [ple_pkg::ValW-1:0]     val_q, val_d;
  logic [CW-1:0]                res_cnt_q, res_cnt_d;
  logic [ple_pkg::StW-1:0]      st_q, st_d;
  logic                         ret_q, ret_d;
  logic                         erase_q, erase_d;
  logic [ple_pkg::OutDataW-1:0] m_data_q, m_data_d;

  // RAM port
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [ple_pkg::ValW-1:0] ram_wdata;
  logic [ple_pkg::ValW-1:0] ram_rdata;

  // Input beat fields
  logic [ple_pkg::OpW-1:0]  in_op;
  logic [ple_pkg::ValW-1:0] in_val;
  logic [ple_pkg::PosW-1:0] in_pos;

  assign in_op  = s_axis_tdata[3:0];
  assign in_val = s_axis_tdata[35:4];
  assign in_pos = s_axis_tdata[41:36];

  // Command decode against the current count
  logic          is_ins, is_take, is_erase;
  logic [PW-1:0] cnt_ext, pos_sel;
  logic [ple_pkg::StW-1:0] dec_st;

  always_comb begin
    cnt_ext  = PW'(count_q);
    is_ins   = 1'b0;
    is_take  = 1'b0;
    is_erase = 1'b0;
    pos_sel  = '0;
    unique case (in_op)
      ple_pkg::OP_INS_FRONT: begin
        is_ins = 1'b1;
      end
      ple_pkg::OP_INS_END: begin
        is_ins  = 1'b1;
        pos_sel = cnt_ext;
      end
      ple_pkg::OP_INS_POS: begin
        is_ins  = 1'b1;
        pos_sel = PW'(in_pos);
      end
      ple_pkg::OP_REM_FRONT: begin
        is_take  = 1'b1;
        is_erase = 1'b1;
      end
      ple_pkg::OP_REM_END: begin
        is_take  = 1'b1;
        is_erase = 1'b1;
        pos_sel  = cnt_ext - PW'(1);
      end
      ple_pkg::OP_REM_POS: begin
        is_take  = 1'b1;
        is_erase = 1'b1;
        pos_sel  = PW'(in_pos);
      end
      ple_pkg::OP_RD_FRONT: begin
        is_take = 1'b1;
      end
      ple_pkg::OP_RD_END: begin
        is_take = 1'b1;
        pos_sel = cnt_ext - PW'(1);
      end
      ple_pkg::OP_RD_POS: begin
        is_take = 1'b1;
        pos_sel = PW'(in_pos);
      end
      default: begin
      end
    endcase

    // Status priority follows the command kind
    dec_st = ple_pkg::ST_OK;
    if (is_ins) begin
      priority if (pos_sel > cnt_ext) dec_st = ple_pkg::ST_BADPOS;
      else if (cnt_ext >= PW'(CAPACITY)) dec_st = ple_pkg::ST_FULL;
      else dec_st = ple_pkg::ST_OK;
    end else if (is_take) begin
      priority if (count_q == '0) dec_st = ple_pkg::ST_EMPTY;
      else if (pos_sel >= cnt_ext) dec_st = ple_pkg::ST_BADPOS;
      else dec_st = ple_pkg::ST_OK;
    end
  end

  // Sequencer
  logic [PW-1:0] res_ext;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    m_valid_d = m_valid_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    val_d     = val_q;
    res_cnt_d = res_cnt_q;
    st_d      = st_q;
    ret_d     = ret_q;
    erase_d   = erase_q;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ram_rdata;
    res_ext   = PW'(res_cnt_q);

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          pos_d     = AW'(pos_sel);
          val_d     = in_val;
          st_d      = dec_st;
          erase_d   = is_erase;
          ret_d     = 1'b0;
          res_cnt_d = count_q;
          state_d   = S_DONE;
          if (dec_st == ple_pkg::ST_OK) begin
            if (is_ins) begin
              res_cnt_d = count_q + CW'(1);
              // read the last entry first and walk down to the slot
              ptr_d   = AW'(cnt_ext - PW'(1));
              state_d = (cnt_ext > pos_sel) ? S_INS_SHIFT : S_INS_PUT;
            end else if (is_take) begin
              ptr_d   = AW'(pos_sel);
              ret_d   = 1'b1;
              state_d = S_TAKE;
              if (is_erase) begin
                res_cnt_d = count_q - CW'(1);
              end
            end
          end
        end
      end

      S_INS_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q + AW'(1);
        if (ptr_q > pos_q) begin
          ptr_d = ptr_q - AW'(1);
        end else begin
          state_d = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = val_q;
        state_d   = S_DONE;
      end

      S_TAKE: begin
        val_d = ram_rdata;
        if (erase_q && (CW'(ptr_q) + CW'(1) < count_q)) begin
          ptr_d   = ptr_q + AW'(1);
          state_d = S_REM_SHIFT;
        end else begin
          state_d = S_DONE;
        end
      end

      S_REM_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q - AW'(1);
        if (CW'(ptr_q) + CW'(1) < count_q) begin
          ptr_d = ptr_q + AW'(1);
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // hand the result over once the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {res_ext[ple_pkg::CntW-1:0], st_q,
                       (ret_q ? val_q : {ple_pkg::ValW{1'b0}})};
          count_d   = res_cnt_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    res_cnt_q <= res_cnt_d;
    st_q      <= st_d;
    ret_q     <= ret_d;
    erase_q   <= erase_d;
    m_data_q  <= m_data_d;
  end

  // Entry store; read address follows the next pointer so data lands with ptr_q
  ple_ram #(
    .WIDTH (ple_pkg::ValW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_d),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[bench/positional_list_engine_tb.sv]
module positional_list_engine_tb;

  localparam int LIST_DEPTH  = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOW_LIMIT  = 10;

  // opcodes the block treats as no-ops
  localparam logic [ple_pkg::OpW-1:0] OP_UNUSED_LO = 4'd9;
  localparam logic [ple_pkg::OpW-1:0] OP_UNUSED_HI = 4'd15;

  localparam logic [ple_pkg::PosW-1:0] POS_MAX     = '1;
  localparam logic [ple_pkg::ValW-1:0] VAL_MIN     = 32'h8000_0000;
  localparam logic [ple_pkg::ValW-1:0] VAL_MAX     = 32'h7fff_ffff;
  localparam logic [ple_pkg::ValW-1:0] VAL_ZERO    = '0;
  localparam logic [ple_pkg::ValW-1:0] VAL_ALL_ONE = '1;

  // result beat layout, low bit up: read value, status, count
  typedef struct packed {
    logic [ple_pkg::CntW-1:0] elem_count;
    logic [ple_pkg::StW-1:0]  status;
    logic [ple_pkg::ValW-1:0] rd_value;
  } list_result_t;

  typedef enum int {KIND_INS, KIND_REM, KIND_RD} cmd_kind_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [ple_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [ple_pkg::OutDataW-1:0] m_axis_tdata;

  // shadow copy of the list contents and length
  logic [ple_pkg::ValW-1:0] list_store [LIST_DEPTH];
  int                       list_len = 0;

  list_result_t    expected_q[$];
  int              mismatch_cnt = 0;
  int              cycle_cnt = 0;
  bit              no_idle = 1'b0;

  positional_list_engine #(.CAPACITY(LIST_DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Apply one command to the shadow list and return the result it should give
  function automatic list_result_t list_predict(input logic [ple_pkg::OpW-1:0] op,
                                                input logic [ple_pkg::ValW-1:0] val,
                                                input logic [ple_pkg::PosW-1:0] pos);
    list_result_t r;
    cmd_kind_e    kind;
    bit           known;
    int           at;
    r     = '0;
    kind  = KIND_RD;
    known = 1'b1;
    at    = 0;
    case (op)
      ple_pkg::OP_INS_FRONT: begin kind = KIND_INS; at = 0;         end
      ple_pkg::OP_INS_END:   begin kind = KIND_INS; at = list_len;  end
      ple_pkg::OP_INS_POS:   begin kind = KIND_INS; at = int'(pos); end
      ple_pkg::OP_REM_FRONT: begin kind = KIND_REM; at = 0;         end
      ple_pkg::OP_REM_END: begin
        kind = KIND_REM;
        at   = (list_len != 0) ? list_len - 1 : 0;
      end
      ple_pkg::OP_REM_POS:   begin kind = KIND_REM; at = int'(pos); end
      ple_pkg::OP_RD_FRONT:  begin kind = KIND_RD;  at = 0;         end
      ple_pkg::OP_RD_END: begin
        kind = KIND_RD;
        at   = (list_len != 0) ? list_len - 1 : 0;
      end
      ple_pkg::OP_RD_POS:    begin kind = KIND_RD;  at = int'(pos); end
      default:               known = 1'b0;
    endcase
    r.status = ple_pkg::ST_OK;
    if (known && kind == KIND_INS) begin
      // position check wins over the full check
      if (at > list_len) begin
        r.status = ple_pkg::ST_BADPOS;
      end else if (list_len >= LIST_DEPTH) begin
        r.status = ple_pkg::ST_FULL;
      end else begin
        for (int i = list_len; i > at; i--) list_store[i] = list_store[i-1];
        list_store[at] = val;
        list_len++;
      end
    end else if (known) begin
      // empty check wins over the position check
      if (list_len == 0) begin
        r.status = ple_pkg::ST_EMPTY;
      end else if (at >= list_len) begin
        r.status = ple_pkg::ST_BADPOS;
      end else begin
        r.rd_value = list_store[at];
        if (kind == KIND_REM) begin
          for (int i = at; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
          list_len--;
        end
      end
    end
    r.elem_count = list_len[ple_pkg::CntW-1:0];
    return r;
  endfunction

  function automatic logic [ple_pkg::ValW-1:0] rand_value();
    case ($urandom_range(19))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_ZERO;
      3:       return VAL_ALL_ONE;
      default: return $urandom;
    endcase
  endfunction

  // one of the three opcodes of a kind, picked at random
  function automatic logic [ple_pkg::OpW-1:0] pick_op(input cmd_kind_e kind);
    int k;
    k = $urandom_range(2);
    case (kind)
      KIND_INS: return (k == 0) ? ple_pkg::OP_INS_FRONT :
                       (k == 1) ? ple_pkg::OP_INS_END : ple_pkg::OP_INS_POS;
      KIND_REM: return (k == 0) ? ple_pkg::OP_REM_FRONT :
                       (k == 1) ? ple_pkg::OP_REM_END : ple_pkg::OP_REM_POS;
      default:  return (k == 0) ? ple_pkg::OP_RD_FRONT :
                       (k == 1) ? ple_pkg::OP_RD_END : ple_pkg::OP_RD_POS;
    endcase
  endfunction

  // a position that is legal for the kind at the current length
  function automatic logic [ple_pkg::PosW-1:0] pick_pos(input cmd_kind_e kind);
    if (kind == KIND_INS) return ple_pkg::PosW'($urandom_range(list_len));
    if (list_len == 0) return '0;
    return ple_pkg::PosW'($urandom_range(list_len - 1));
  endfunction

  // Send one command beat; predict its result once it is taken
  task automatic issue_cmd(input logic [ple_pkg::OpW-1:0] op,
                           input logic [ple_pkg::ValW-1:0] val,
                           input logic [ple_pkg::PosW-1:0] pos);
    while (!no_idle && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(ple_pkg::InDataW-ple_pkg::OpW-ple_pkg::ValW-ple_pkg::PosW){1'b0}},
                      pos, val, op};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.insert(expected_q.size(), list_predict(op, val, pos));
  endtask

  task automatic report_mismatch(input string what, input list_result_t want,
                                 input list_result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= SHOW_LIMIT)
      $display("cycle %0d: %s: expected value %h status %0d count %0d, got value %h status %0d count %0d",
               cycle_cnt, what, want.rd_value, want.status, want.elem_count,
               got.rd_value, got.status, got.elem_count);
  endtask

  // Result beat checker and receiver backpressure
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.rd_value !== want.rd_value || got.status !== want.status ||
            got.elem_count !== want.elem_count)
          report_mismatch("result mismatch", want, got);
      end
    end
    m_axis_tready <= no_idle || ($urandom_range(99) >= 38);
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("positional_list_engine test failed");
      $finish;
    end
  end

  // Commands on an empty list, including bad positions and unused opcodes
  task automatic test_empty_list();
    issue_cmd(ple_pkg::OP_REM_FRONT, rand_value(), '0);
    issue_cmd(ple_pkg::OP_REM_END,   rand_value(), '0);
    issue_cmd(ple_pkg::OP_REM_POS,   rand_value(), POS_MAX);
    issue_cmd(ple_pkg::OP_RD_FRONT,  rand_value(), '0);
    issue_cmd(ple_pkg::OP_RD_END,    rand_value(), '0);
    issue_cmd(ple_pkg::OP_RD_POS,    rand_value(), '0);
    issue_cmd(OP_UNUSED_LO,          VAL_ALL_ONE,  POS_MAX);
    issue_cmd(OP_UNUSED_HI,          VAL_MIN,      '0);
    issue_cmd(ple_pkg::OP_INS_POS,   VAL_MAX,      ple_pkg::PosW'(1));
  endtask

  // Extreme values, append by position, bad positions on a short list
  task automatic test_edge_values();
    issue_cmd(ple_pkg::OP_INS_END,   VAL_MIN,      '0);
    issue_cmd(ple_pkg::OP_INS_FRONT, VAL_MAX,      '0);
    issue_cmd(ple_pkg::OP_INS_POS,   VAL_ZERO,     ple_pkg::PosW'(1));
    issue_cmd(ple_pkg::OP_INS_POS,   VAL_ALL_ONE,  ple_pkg::PosW'(3));
    issue_cmd(ple_pkg::OP_INS_POS,   rand_value(), ple_pkg::PosW'(5));
    issue_cmd(ple_pkg::OP_RD_FRONT,  '0, '0);
    issue_cmd(ple_pkg::OP_RD_END,    '0, '0);
    issue_cmd(ple_pkg::OP_RD_POS,    '0, ple_pkg::PosW'(2));
    issue_cmd(ple_pkg::OP_RD_POS,    '0, ple_pkg::PosW'(4));
    issue_cmd(OP_UNUSED_LO,          rand_value(), ple_pkg::PosW'(2));
    issue_cmd(ple_pkg::OP_REM_POS,   '0, ple_pkg::PosW'(1));
    issue_cmd(ple_pkg::OP_REM_POS,   '0, ple_pkg::PosW'(3));
    issue_cmd(ple_pkg::OP_REM_END,   '0, '0);
    issue_cmd(ple_pkg::OP_REM_FRONT, '0, '0);
    issue_cmd(ple_pkg::OP_REM_POS,   '0, '0);
  endtask

  // Fill to capacity, poke at the full list, then drain it
  task automatic test_full_list();
    while (list_len < LIST_DEPTH)
      issue_cmd(pick_op(KIND_INS), rand_value(), pick_pos(KIND_INS));
    issue_cmd(ple_pkg::OP_INS_FRONT, rand_value(), '0);
    issue_cmd(ple_pkg::OP_INS_END,   rand_value(), '0);
    issue_cmd(ple_pkg::OP_INS_POS,   rand_value(), ple_pkg::PosW'(LIST_DEPTH));
    issue_cmd(ple_pkg::OP_INS_POS,   rand_value(), ple_pkg::PosW'(LIST_DEPTH + 1));
    issue_cmd(ple_pkg::OP_INS_POS,   rand_value(), POS_MAX);
    issue_cmd(ple_pkg::OP_RD_POS,    '0, ple_pkg::PosW'(LIST_DEPTH - 1));
    issue_cmd(ple_pkg::OP_RD_POS,    '0, ple_pkg::PosW'(LIST_DEPTH));
    issue_cmd(ple_pkg::OP_RD_END,    '0, '0);
    issue_cmd(ple_pkg::OP_REM_POS,   '0, ple_pkg::PosW'(LIST_DEPTH - 1));
    issue_cmd(ple_pkg::OP_INS_POS,   rand_value(), ple_pkg::PosW'(LIST_DEPTH - 1));
    issue_cmd(ple_pkg::OP_REM_POS,   '0, '0);
    while (list_len > 0) issue_cmd(pick_op(KIND_REM), '0, pick_pos(KIND_REM));
  endtask

  // Random traffic that sweeps the length between empty and full
  task automatic random_walk(input int n_cmds);
    bit        growing;
    int        roll;
    cmd_kind_e kind;
    growing = 1'b1;
    for (int i = 0; i < n_cmds; i++) begin
      if (list_len >= LIST_DEPTH) growing = 1'b0;
      else if (list_len == 0) growing = 1'b1;
      else if ($urandom_range(49) == 0) growing = !growing;
      roll = $urandom_range(99);
      if (roll < 8) begin
        // noise: any opcode, any position
        issue_cmd(ple_pkg::OpW'($urandom_range(15)), rand_value(),
                  ple_pkg::PosW'($urandom_range(63)));
      end else begin
        if (roll < 30) kind = KIND_RD;
        else if ($urandom_range(99) < (growing ? 75 : 25)) kind = KIND_INS;
        else kind = KIND_REM;
        issue_cmd(pick_op(kind), rand_value(), pick_pos(kind));
      end
    end
  endtask

  task automatic test_random_idle();
    random_walk(900);
  endtask

  // Both sides at full rate
  task automatic test_back_to_back();
    no_idle = 1'b1;
    random_walk(250);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edge_values();
    test_full_list();
    test_random_idle();
    test_back_to_back();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LIST_DEPTH + 8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("positional_list_engine test passed");
    end else begin
      $display("positional_list_engine test failed");
    end
    $finish;
  end

endmodule
